@@ src/ordered_list_with_value_removal_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_WITH_VALUE_REMOVAL_UNIT_ASSERT_SVH
`define ORDERED_LIST_WITH_VALUE_REMOVAL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define OLVR_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Check that a condition implies another in the same cycle
`define OLVR_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define OLVR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define OLVR_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define OLVR_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define OLVR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

@@ src/olvr_pkg.sv @@
// ----------------------------------------------------------------------------
// olvr_pkg
// Shared constants, codes and types of the ordered list unit.
// ----------------------------------------------------------------------------
package olvr_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   // Request action codes
   localparam logic [1:0] ACT_FRONT  = 2'd0;
   localparam logic [1:0] ACT_BACK   = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   // Response status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_FULL     = 2'd1;
   localparam logic [1:0] STS_NOTFOUND = 2'd2;

   // Control broadcast from the top level to every cell
   typedef struct packed {
      logic       enable;
      logic [1:0] action;
      logic       full;
   } olvr_ctrl_type;

endpackage

@@ src/olvr_cell.sv @@
// ----------------------------------------------------------------------------
// olvr_cell
// One list slot: holds an entry and its valid bit, compares it with the
// request value and, per action, shifts to either neighbor or takes that value.
// ----------------------------------------------------------------------------
module olvr_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  olvr_pkg::olvr_ctrl_type       ctrl,
   input  logic [olvr_pkg::DATA_W-1:0]   req_data,
   input  logic                          left_valid,
   input  logic [olvr_pkg::DATA_W-1:0]   left_data,
   input  logic                          right_valid,
   input  logic [olvr_pkg::DATA_W-1:0]   right_data,
   input  logic                          hit_in,
   output logic                          valid,
   output logic [olvr_pkg::DATA_W-1:0]   data,
   output logic                          hit_out
);
   import olvr_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // Pass on whether a match was seen at or before this slot
   assign hit_out = hit_in |
                    (valid_ff && (data_ff == req_data) && (ctrl.action == ACT_REMOVE));

   // Pick the next contents of this slot
   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.enable) begin
         case (ctrl.action)
            ACT_FRONT: begin
               if (!ctrl.full) begin
                  data_in  = left_data;
                  valid_in = left_valid;
               end
            end
            ACT_BACK: begin
               if (!ctrl.full && left_valid && !valid_ff) begin
                  data_in  = req_data;
                  valid_in = 1'b1;
               end
            end
            ACT_REMOVE: begin
               if (hit_out) begin
                  data_in  = right_data;
                  valid_in = right_valid;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Hold the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the entry
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

@@ src/ordered_list_with_value_removal_unit.sv @@
// ----------------------------------------------------------------------------
// ordered_list_with_value_removal_unit
// Bounded ordered list of signed values held in a row of slots.
//
// Usage: drive req_action and req_value and raise start; the request beat is
// taken at any rising edge where start is high and busy is low. busy stays
// low, so a new request may be issued in every cycle. Actions: insert at the
// front, append at the back, remove the first entry equal to req_value.
// Every request beat yields one response beat on the rsp_ ports, marked by
// rsp_valid for exactly one cycle, in the cycle after the request edge;
// throughput 1 request per cycle. All slots compare and shift in the same
// cycle; the match flag ripples once along the slot row. The response
// carries the status, the new count, the empty flag and the head and tail
// values (zero when empty). The receiver cannot stall: each response beat
// is valid for a single cycle only. A synchronous reset empties the list at
// once and drops any pending response.
// ----------------------------------------------------------------------------
module ordered_list_with_value_removal_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic signed [olvr_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   output logic [1:0]                           rsp_status,
   output logic [olvr_pkg::COUNT_W-1:0]         rsp_count,
   output logic                                 rsp_list_empty,
   output logic signed [olvr_pkg::DATA_W-1:0]   rsp_head_value,
   output logic signed [olvr_pkg::DATA_W-1:0]   rsp_tail_value
);
   import olvr_pkg::*;

   `include "ordered_list_with_value_removal_unit_assert.svh"

   olvr_ctrl_type       ctrl;
   logic                accept;
   logic [DATA_W-1:0]   value_u;
   logic [CAPACITY-1:0] valid_vec;
   logic [DATA_W-1:0]   data_q [CAPACITY];
   logic [CAPACITY:0]   hit;
   logic [CAPACITY-1:0] tail_mask;
   logic [DATA_W-1:0]   tail_data;

   logic                rsp_valid_ff;
   logic [1:0]          status_ff;
   logic [1:0]          status_in;
   logic [COUNT_W-1:0]  count_ff;
   logic [COUNT_W-1:0]  count_in;

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign value_u = DATA_W'(unsigned'(req_value));

   // Broadcast the request to the slots
   assign ctrl.enable = accept;
   assign ctrl.action = req_action;
   assign ctrl.full   = valid_vec[CAPACITY-1];

   assign hit[0] = 1'b0;

   // Build the slot row
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic              lv;
      logic [DATA_W-1:0] ld;
      logic              rv;
      logic [DATA_W-1:0] rd;

      if (i == 0) begin : g_first
         assign lv = 1'b1;
         assign ld = value_u;
      end else begin : g_mid_left
         assign lv = valid_vec[i-1];
         assign ld = data_q[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rv = 1'b0;
         assign rd = '0;
      end else begin : g_mid_right
         assign rv = valid_vec[i+1];
         assign rd = data_q[i+1];
      end

      olvr_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .req_data    (value_u),
         .left_valid  (lv),
         .left_data   (ld),
         .right_valid (rv),
         .right_data  (rd),
         .hit_in      (hit[i]),
         .valid       (valid_vec[i]),
         .data        (data_q[i]),
         .hit_out     (hit[i+1])
      );
   end

   // Work out status and new count of the request
   always_comb begin
      status_in = STS_OK;
      count_in  = count_ff;
      case (req_action) inside
         ACT_FRONT, ACT_BACK: begin
            if (ctrl.full) begin
               status_in = STS_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
            end
         end
         ACT_REMOVE: begin
            if (hit[CAPACITY]) begin
               count_in = count_ff - COUNT_W'(1);
            end else begin
               status_in = STS_NOTFOUND;
            end
         end
         default: begin
         end
      endcase
   end

   // Hold count, status and the response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   // Select the tail: the last valid slot
   assign tail_mask = valid_vec & ~(valid_vec >> 1);

   always_comb begin
      tail_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_data = tail_data | (data_q[i] & {DATA_W{tail_mask[i]}});
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = count_ff;
   assign rsp_list_empty = !valid_vec[0];
   assign rsp_head_value = valid_vec[0] ? signed'(data_q[0]) : '0;
   assign rsp_tail_value = signed'(tail_data);

   // Check count against valid bits, their packing, rsp timing, full no-growth
   `OLVR_ASSERT_ALWAYS(a_count_match, clock, reset,
      $countones(valid_vec) == 32'(count_ff))
   `OLVR_ASSERT_ALWAYS(a_valid_packed, clock, reset,
      ((({1'b0, valid_vec}) + (CAPACITY+1)'(1)) & {1'b0, valid_vec}) == '0)
   `OLVR_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid)
   `OLVR_ASSERT_IMPLY(a_full_no_grow, clock, reset,
      accept && ctrl.full && (req_action == ACT_FRONT || req_action == ACT_BACK),
      count_in == count_ff)

endmodule
